// ----- design/lgr_pkg.sv -----
// Shared types and constants for the Life generation row engine.
// No dependencies; every other file imports this package.
`default_nettype none

package lgr_pkg;

  // Field width of one row on the channels, and the live part of it
  localparam int ROW_W      = 64;
  localparam int GRID_WIDTH = 64;

  // B3/S23 neighbor counts
  localparam int NBR_W         = 4;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  // Result queue geometry
  localparam int Q_PTR_W = 2;
  localparam int Q_DEPTH = 1 << Q_PTR_W;
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef logic [ROW_W-1:0] row_t;

  // One finished result row
  typedef struct packed {
    row_t cells;
    logic frame_end;
  } lgr_result_t;

  // Pushes into the result queue for one accepted row
  typedef struct packed {
    logic        push_a;
    lgr_result_t entry_a;
    logic        push_b;
    lgr_result_t entry_b;
  } lgr_push_t;

endpackage

`default_nettype wire

// ----- design/lgr_stream_if.sv -----
// Valid/ready channel interfaces for the row input and the result output.
// Depends on lgr_pkg for the row type.
`default_nettype none

interface lgr_row_in_if import lgr_pkg::*; ();
  logic valid;
  logic ready;
  row_t row_cells;
  logic last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgr_row_out_if import lgr_pkg::*; ();
  logic valid;
  logic ready;
  row_t next_row_cells;
  logic frame_end;

  modport source (output valid, output next_row_cells, output frame_end, input ready);
  modport sink   (input valid, input next_row_cells, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/lgr_cell_lane.sv -----
// One cell lane: counts the eight neighbors and applies rule B3/S23.
// Depends on lgr_pkg for the count constants.
`default_nettype none

module lgr_cell_lane
  import lgr_pkg::*;
(
  input  wire logic [2:0] up_win,
  input  wire logic [2:0] mid_win,
  input  wire logic [2:0] down_win,
  output logic            next_cell
);

  logic [NBR_W-1:0] nbr_count;

  // Sum the neighbors; the center of mid_win is the cell itself
  always_comb begin
    nbr_count = NBR_W'(up_win[0]) + NBR_W'(up_win[1]) + NBR_W'(up_win[2])
              + NBR_W'(mid_win[0]) + NBR_W'(mid_win[2])
              + NBR_W'(down_win[0]) + NBR_W'(down_win[1]) + NBR_W'(down_win[2]);
    next_cell = (nbr_count == NBR_W'(BIRTH_COUNT))
             || ((nbr_count == NBR_W'(SURVIVE_COUNT)) && mid_win[1]);
  end

endmodule

`default_nettype wire

// ----- design/lgr_row_unit.sv -----
// Next generation of one row: one cell lane per grid column, merged into a row.
// Depends on lgr_pkg and lgr_cell_lane.
`default_nettype none

module lgr_row_unit
  import lgr_pkg::*;
(
  input  wire row_t up_row,
  input  wire row_t mid_row,
  input  wire row_t down_row,
  output row_t      next_row
);

  // Pad each row with a dead cell on both sides of the grid
  logic [GRID_WIDTH+1:0] up_pad;
  logic [GRID_WIDTH+1:0] mid_pad;
  logic [GRID_WIDTH+1:0] down_pad;
  logic [GRID_WIDTH-1:0] lane_out;

  assign up_pad   = {1'b0, up_row[GRID_WIDTH-1:0], 1'b0};
  assign mid_pad  = {1'b0, mid_row[GRID_WIDTH-1:0], 1'b0};
  assign down_pad = {1'b0, down_row[GRID_WIDTH-1:0], 1'b0};

  for (genvar i = 0; i < GRID_WIDTH; i++) begin : g_lane
    lgr_cell_lane u_lane (
      .up_win   (up_pad[i+2:i]),
      .mid_win  (mid_pad[i+2:i]),
      .down_win (down_pad[i+2:i]),
      .next_cell(lane_out[i])
    );
  end

  // Merge lane outputs; columns beyond the grid stay dead
  if (GRID_WIDTH < ROW_W) begin : g_pad_out
    assign next_row = {{(ROW_W-GRID_WIDTH){1'b0}}, lane_out};
  end else begin : g_full_out
    assign next_row = lane_out;
  end

endmodule

`default_nettype wire

// ----- design/lgr_out_queue.sv -----
// Result queue: takes up to two result rows per cycle, sends one per beat.
// Depends on lgr_pkg and lgr_row_out_if.
`default_nettype none

module lgr_out_queue
  import lgr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lgr_push_t push,
  output logic           room_for_two,
  lgr_row_out_if.source  out_res
);

  lgr_result_t        mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_b;
  logic               pop;

  assign pop          = out_res.valid && out_res.ready;
  assign room_for_two = count_r <= Q_CNT_W'(Q_DEPTH - 2);
  assign wr_ptr_b     = wr_ptr_r + Q_PTR_W'(push.push_a);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.push_a) + Q_PTR_W'(push.push_b);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.push_a) + Q_CNT_W'(push.push_b)
               - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; the earlier row goes in first
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem[wr_ptr_r] <= push.entry_a;
    end
    if (push.push_b) begin
      mem[wr_ptr_b] <= push.entry_b;
    end
  end

  // Present the head entry
  assign out_res.valid          = count_r != '0;
  assign out_res.next_row_cells = mem[rd_ptr_r].cells;
  assign out_res.frame_end      = mem[rd_ptr_r].frame_end;

endmodule

`default_nettype wire

// ----- design/life_generation_row_engine_top.sv -----
// Top level of the Life generation row engine (rule B3/S23, rows in raster order).
// Depends on lgr_pkg, the stream interfaces, lgr_row_unit and lgr_out_queue.
//
//   channel   direction  payload                          handshake
//   in_row    sink       row_cells[63:0], last_row        valid/ready
//   out_res   source     next_row_cells[63:0], frame_end  valid/ready
//
// A row is taken in the cycle it arrives, one row per cycle; its results
// (none, one, or two on a frame's last row) enter a four-entry result queue
// in the same cycle and leave one per beat from the next cycle on. Input is
// held off only while the queue has fewer than two free entries.
// Synchronous active-low reset clears the stored rows and the queue.
`default_nettype none

module life_generation_row_engine_top
  import lgr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  lgr_row_in_if.sink    in_row,
  lgr_row_out_if.source out_res
);

  row_t             row_above_r, row_above_nxt;
  row_t             row_middle_r, row_middle_nxt;
  logic [1:0]       rows_seen_r, rows_seen_nxt;
  row_t             row_in;
  row_t             up_b;
  row_t             gen_a;
  row_t             gen_b;
  logic             accept;
  logic             room_for_two;
  logic             have_rows;
  lgr_push_t        push;

  assign in_row.ready = room_for_two;
  assign accept       = in_row.valid && in_row.ready;
  assign have_rows    = rows_seen_r != 2'd0;

  // Drop cells beyond the grid
  if (GRID_WIDTH < ROW_W) begin : g_mask
    assign row_in = {{(ROW_W-GRID_WIDTH){1'b0}}, in_row.row_cells[GRID_WIDTH-1:0]};
  end else begin : g_nomask
    assign row_in = in_row.row_cells;
  end

  // Finish the stored middle row, using the new row below it
  lgr_row_unit u_gen_a (
    .up_row  (row_above_r),
    .mid_row (row_middle_r),
    .down_row(row_in),
    .next_row(gen_a)
  );

  // Finish the frame's last row, with a dead row below
  assign up_b = have_rows ? row_middle_r : '0;

  lgr_row_unit u_gen_b (
    .up_row  (up_b),
    .mid_row (row_in),
    .down_row('0),
    .next_row(gen_b)
  );

  // Build the queue pushes for this beat
  always_comb begin
    push.push_a            = accept && have_rows;
    push.entry_a.cells     = gen_a;
    push.entry_a.frame_end = 1'b0;
    push.push_b            = accept && in_row.last_row;
    push.entry_b.cells     = gen_b;
    push.entry_b.frame_end = 1'b1;
  end

  // Shift the row window; clear it after the last row
  always_comb begin
    row_above_nxt  = row_above_r;
    row_middle_nxt = row_middle_r;
    rows_seen_nxt  = rows_seen_r;
    if (accept) begin
      if (in_row.last_row) begin
        row_above_nxt  = '0;
        row_middle_nxt = '0;
        rows_seen_nxt  = 2'd0;
      end else begin
        row_above_nxt  = up_b;
        row_middle_nxt = row_in;
        rows_seen_nxt  = (rows_seen_r == 2'd2) ? 2'd2 : rows_seen_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r  <= '0;
      row_middle_r <= '0;
      rows_seen_r  <= 2'd0;
    end else begin
      row_above_r  <= row_above_nxt;
      row_middle_r <= row_middle_nxt;
      rows_seen_r  <= rows_seen_nxt;
    end
  end

  lgr_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .room_for_two(room_for_two),
    .out_res     (out_res)
  );

endmodule

`default_nettype wire

// ----- test/life_generation_row_engine_checker.sv -----
// Checker for the Life generation row engine: watches both channels, predicts each
// generation row from the accepted input rows and compares the result beats.
// Depends on lgr_pkg for the row and result types.
`default_nettype none

module life_generation_row_engine_checker
  import lgr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire row_t in_cells,
  input  wire logic in_last,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire row_t out_cells,
  input  wire logic out_frame_end,
  output int        error_count,
  output int        rows_pending
);

  // Cells at or above GRID_WIDTH are not part of the grid
  localparam row_t GRID_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_WIDTH);

  // Predicted frame state: two stored rows and how many rows this frame holds, capped at two
  row_t        grid_above;
  row_t        grid_middle;
  logic [1:0]  rows_held;
  lgr_result_t expected_rows[$];
  int          errors_seen;

  // Next generation of mid under B3/S23; cells beyond either edge are dead
  function automatic row_t life_step(row_t up, row_t mid, row_t down);
    row_t nxt;
    int   n;
    nxt = '0;
    for (int i = 0; i < GRID_WIDTH; i++) begin
      n = 0;
      for (int j = i - 1; j <= i + 1; j++) begin
        if (j >= 0 && j < GRID_WIDTH) begin
          n += up[j] + down[j];
          if (j != i) n += mid[j];
        end
      end
      nxt[i] = (n == BIRTH_COUNT) || (n == SURVIVE_COUNT && mid[i]);
    end
    return nxt;
  endfunction

  always @(posedge clk) begin
    lgr_result_t want;
    row_t        row;
    if (!rst_n) begin
      // Drop everything predicted so far
      expected_rows.delete();
      grid_above  = '0;
      grid_middle = '0;
      rows_held   = '0;
    end else begin
      // Compare a result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result beat: next_row_cells=%h frame_end=%b",
                 out_cells, out_frame_end);
          errors_seen++;
        end else begin
          want = expected_rows.pop_front();
          if (out_cells !== want.cells) begin
            $error("next_row_cells mismatch: expected %h actual %h", want.cells, out_cells);
            errors_seen++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %b actual %b", want.frame_end,
                   out_frame_end);
            errors_seen++;
          end
        end
      end

      // Advance the predicted frame by one accepted row beat
      if (in_valid && in_ready) begin
        row = in_cells & GRID_MASK;
        if (rows_held != 2'd0) begin
          want.cells     = life_step(grid_above, grid_middle, row);
          want.frame_end = 1'b0;
          expected_rows.push_back(want);
          grid_above = grid_middle;
        end else begin
          grid_above = '0;
        end
        grid_middle = row;
        if (rows_held < 2'd2) rows_held++;

        // Last row: finish it against a dead row below, then clear the frame
        if (in_last) begin
          want.cells     = life_step(grid_above, grid_middle, '0);
          want.frame_end = 1'b1;
          expected_rows.push_back(want);
          grid_above  = '0;
          grid_middle = '0;
          rows_held   = '0;
        end
      end
    end
    error_count  <= errors_seen;
    rows_pending <= expected_rows.size();
  end

endmodule

`default_nettype wire

// ----- test/life_generation_row_engine_top_tb.sv -----
// Testbench top for the Life generation row engine: clock, reset, row stimulus,
// result-side stalls and the verdict. Depends on lgr_pkg, the stream interfaces,
// the engine top and life_generation_row_engine_checker.
`default_nettype none

module life_generation_row_engine_top_tb
  import lgr_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ROWS  = 350;
  localparam int MAX_GAP     = 40;

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   error_count;
  int   rows_pending;
  int   rows_sent;

  lgr_row_in_if  in_row();
  lgr_row_out_if out_res();

  life_generation_row_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_row (in_row),
    .out_res(out_res)
  );

  life_generation_row_engine_checker check_u (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_row.valid),
    .in_ready     (in_row.ready),
    .in_cells     (in_row.row_cells),
    .in_last      (in_row.last_row),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .out_cells    (out_res.next_row_cells),
    .out_frame_end(out_res.frame_end),
    .error_count  (error_count),
    .rows_pending (rows_pending)
  );

  always #2 clk = ~clk;

  // Stall the result side at the current phase's rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one row beat, after a random idle gap, and hold it until accepted
  task automatic send_row(input row_t cells, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_row.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_row.valid     <= 1'b1;
    in_row.row_cells <= cells;
    in_row.last_row  <= last;
    @(posedge clk);
    while (!in_row.ready) @(posedge clk);
    rows_sent++;
  endtask

  // Hold input off until every predicted row has come out
  task automatic wait_drained();
    in_row.valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
  endtask

  // Random row content: plain, sparse, dense or a small blob that may touch an edge
  function automatic row_t random_row();
    row_t a;
    row_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       return a;
      1:       return a & b & {$urandom, $urandom};
      2:       return a | b;
      default: return row_t'($urandom_range(7)) << $urandom_range(ROW_W - 1);
    endcase
  endfunction

  // One frame of random rows, the last one flagged
  task automatic send_frame();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    for (int r = 0; r < len; r++) send_row(random_row(), r == len - 1);
  endtask

  initial begin
    int phase_start;
    rst_n            = 1'b0;
    rows_sent        = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    in_row.valid     = 1'b0;
    in_row.row_cells = '0;
    in_row.last_row  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-row frames: full, empty, both edge cells
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    // Two full rows: top and bottom rows only
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // Horizontal blinkers at the low and the high edge
    send_row('0, 1'b0);
    send_row(64'h0000_0000_0000_0007, 1'b0);
    send_row('0, 1'b1);
    send_row('0, 1'b0);
    send_row(64'hE000_0000_0000_0000, 1'b0);
    send_row('0, 1'b1);
    // Glider
    send_row(64'h2, 1'b0);
    send_row(64'h4, 1'b0);
    send_row(64'h7, 1'b0);
    send_row('0, 1'b0);
    send_row('0, 1'b1);
    // Checkerboard
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Vertical blinker on the top cell
    send_row(64'h8000_0000_0000_0000, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b1);
    wait_drained();

    // Random frames across the idle and stall phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      phase_start = rows_sent;
      while (rows_sent - phase_start < PHASE_ROWS) begin
        send_frame();
        // In the stall phase, let the result side empty out in mid-phase
        if (p == 2 && rows_sent - phase_start >= PHASE_ROWS / 2 &&
            rows_sent - phase_start < PHASE_ROWS / 2 + 25) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    // Settle, then give the verdict
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
